### rtl/lmlor_pkg.sv
package lmlor_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned PosW    = 10;
  localparam int unsigned IncW    = 40;
  localparam int unsigned TimeW   = 64;
  localparam int unsigned CoordW  = 16;
  localparam int unsigned FarZW   = 17;
  localparam int unsigned TickW   = 32;
  localparam int unsigned SepW    = 16;

  // one decoded data word, handed from the front end to the back end
  typedef struct packed {
    logic            emit;
    logic [IncW-1:0] inc;
    logic [PosW-1:0] xn;
    logic [PosW-1:0] yn;
    logic [PosW-1:0] xf;
    logic [PosW-1:0] yf;
  } lmlor_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } lmlor_qstat_t;

endpackage

### rtl/gamma_camera_listmode_lor_decoder_unit.sv
// Channel   Dir  Handshake                        Payload
// in        in   in_valid_i / in_ready_o          word_i
// out       out  out_valid_o / out_ready_i        lor_time_o, x/y near, x/y far, far_z_o
// cfg       in   psel, penable, pwrite; pready=1  ms_per_tick (0x0), head_spacing (0x4)
//
// One word per cycle while the queue has room. A line's last word passes through the
// queue into the output register behind out_valid_o. The rate-setting loop is the
// 64-bit time accumulator add in the back end. Reset clears flags, tag, time and queue.
// A stalled output holds back only emitting entries; the queue between the
// decoder and the accumulator absorbs QUEUE_DEPTH words before in_ready_o falls.
module gamma_camera_listmode_lor_decoder_unit #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [lmlor_pkg::WordW-1:0]   word_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [lmlor_pkg::TimeW-1:0]   lor_time_o,
  output logic [lmlor_pkg::CoordW-1:0]  x_near_o,
  output logic [lmlor_pkg::CoordW-1:0]  y_near_o,
  output logic [lmlor_pkg::CoordW-1:0]  x_far_o,
  output logic [lmlor_pkg::CoordW-1:0]  y_far_o,
  output logic [lmlor_pkg::FarZW-1:0]   far_z_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import lmlor_pkg::*;

  localparam logic       RegTick = 1'b0;
  localparam logic       RegSep  = 1'b1;
  localparam logic [TickW-1:0] TickReset = 32'h0100_0000;

  logic [TickW-1:0] ms_per_tick_q;
  logic [SepW-1:0]  head_spacing_q;
  logic             wr_en;

  logic             push, pop;
  lmlor_entry_t     entry, head;
  lmlor_qstat_t     qstat;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign prdata = (paddr[2] == RegSep) ? {16'h0000, head_spacing_q} : ms_per_tick_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ms_per_tick_q  <= TickReset;
      head_spacing_q <= '0;
    end else if (wr_en) begin
      if (paddr[2] == RegTick) begin
        ms_per_tick_q <= pwdata;
      end else begin
        head_spacing_q <= pwdata[SepW-1:0];
      end
    end
  end

  lmlor_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .word_i        (word_i),
    .ms_per_tick_i (ms_per_tick_q),
    .q_full_i      (qstat.full),
    .push_o        (push),
    .entry_o       (entry)
  );

  lmlor_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .pop_i   (pop),
    .head_o  (head),
    .stat_o  (qstat)
  );

  lmlor_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head),
    .qstat_i        (qstat),
    .pop_o          (pop),
    .head_spacing_i (head_spacing_q),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .lor_time_o     (lor_time_o),
    .x_near_o       (x_near_o),
    .y_near_o       (y_near_o),
    .x_far_o        (x_far_o),
    .y_far_o        (y_far_o),
    .far_z_o        (far_z_o)
  );

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !qstat.full)
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !qstat.empty)
    else $error("pop from an empty queue");

  a_no_clobber: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && head.emit) |-> (!out_valid_o || out_ready_i))
    else $error("pending result overwritten");

  a_emit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && head.emit) |=> out_valid_o)
    else $error("emitted entry did not reach the output");

endmodule

### rtl/lmlor_front.sv
module lmlor_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [lmlor_pkg::WordW-1:0]     word_i,
  input  logic [lmlor_pkg::TickW-1:0]     ms_per_tick_i,
  input  logic                            q_full_i,
  output logic                            push_o,
  output lmlor_pkg::lmlor_entry_t         entry_o
);
  import lmlor_pkg::*;

  localparam logic [WordW-1:0] MarkerWord = 32'hFACE_FACE;
  localparam logic [7:0]       TagLimit   = 8'd130;

  localparam int unsigned FXn     = 0;
  localparam int unsigned FYn     = 1;
  localparam int unsigned FXf     = 2;
  localparam int unsigned FYf     = 3;
  localparam int unsigned FFirst  = 4;
  localparam int unsigned FSecond = 5;

  logic            skip_q, skip_d;
  logic [7:0]      last_tag_q, last_tag_d;
  logic [5:0]      flags_q, flags_d;
  logic [PosW-1:0] xn_q, yn_q, xf_q, yf_q;
  logic [PosW-1:0] xn_d, yn_d, xf_d, yf_d;

  logic            accept, is_data;
  logic [7:0]      tag, diff;
  logic [PosW-1:0] pos;
  logic            tx, ty, far_head, second;
  logic [5:0]      f;
  logic            emit;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign is_data    = !skip_q && (word_i != MarkerWord);

  assign tag  = word_i[31:24];
  assign diff = tag - last_tag_q;

  // inverted, descrambled position bits (top ten of a 14-bit ones' complement)
  assign pos = ~{word_i[8], word_i[10], word_i[12], word_i[14], word_i[16],
                 word_i[21], word_i[19], word_i[18], word_i[11], word_i[13]};

  assign tx       = !word_i[7];
  assign ty       = !word_i[9];
  assign far_head = !word_i[23];
  assign second   = word_i[22];

  always_comb begin
    f    = flags_q;
    xn_d = xn_q;
    yn_d = yn_q;
    xf_d = xf_q;
    yf_d = yf_q;
    if (tx) begin
      if (second) begin
        f[FSecond] = 1'b1;
      end else begin
        f[FFirst] = 1'b1;
        f[FYf:FXn] = 4'b0000;
      end
      if (far_head) begin
        xf_d = pos;
        f[FXf] = 1'b1;
      end else begin
        xn_d = pos;
        f[FXn] = 1'b1;
      end
    end
    if (ty) begin
      if (far_head) begin
        yf_d = pos;
        f[FYf] = 1'b1;
      end else begin
        yn_d = pos;
        f[FYn] = 1'b1;
      end
    end
    emit    = &f;
    flags_d = emit ? 6'b000000 : f;
  end

  always_comb begin
    skip_d     = skip_q;
    last_tag_d = last_tag_q;
    if (accept) begin
      if (skip_q) begin
        skip_d = 1'b0;
      end else if (word_i == MarkerWord) begin
        skip_d = 1'b1;
      end else begin
        last_tag_d = tag;
      end
    end
  end

  assign push_o     = accept && is_data;
  assign entry_o.emit = emit;
  assign entry_o.inc  = (diff < TagLimit) ? (IncW'(diff) * IncW'(ms_per_tick_i)) : '0;
  assign entry_o.xn   = xn_d;
  assign entry_o.yn   = yn_d;
  assign entry_o.xf   = xf_d;
  assign entry_o.yf   = yf_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_q     <= 1'b0;
      last_tag_q <= '0;
      flags_q    <= '0;
      xn_q       <= '0;
      yn_q       <= '0;
      xf_q       <= '0;
      yf_q       <= '0;
    end else begin
      skip_q     <= skip_d;
      last_tag_q <= last_tag_d;
      if (push_o) begin
        flags_q <= flags_d;
        xn_q    <= xn_d;
        yn_q    <= yn_d;
        xf_q    <= xf_d;
        yf_q    <= yf_d;
      end
    end
  end

endmodule

### rtl/lmlor_queue.sv
module lmlor_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  lmlor_pkg::lmlor_entry_t entry_i,
  input  logic                    pop_i,
  output lmlor_pkg::lmlor_entry_t head_o,
  output lmlor_pkg::lmlor_qstat_t stat_o
);
  import lmlor_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  lmlor_entry_t    slots_q [DEPTH];
  logic [AW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]   cnt_q, cnt_d;

  function automatic logic [AW-1:0] nxt(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign stat_o.full  = (cnt_q == CW'(DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign head_o       = slots_q[rd_q];

  always_comb begin
    wr_d  = push_i ? nxt(wr_q) : wr_q;
    rd_d  = pop_i ? nxt(rd_q) : rd_q;
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_q] <= entry_i;
    end
  end

endmodule

### rtl/lmlor_back.sv
module lmlor_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lmlor_pkg::lmlor_entry_t       head_i,
  input  lmlor_pkg::lmlor_qstat_t       qstat_i,
  output logic                          pop_o,
  input  logic [lmlor_pkg::SepW-1:0]    head_spacing_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [lmlor_pkg::TimeW-1:0]   lor_time_o,
  output logic [lmlor_pkg::CoordW-1:0]  x_near_o,
  output logic [lmlor_pkg::CoordW-1:0]  y_near_o,
  output logic [lmlor_pkg::CoordW-1:0]  x_far_o,
  output logic [lmlor_pkg::CoordW-1:0]  y_far_o,
  output logic [lmlor_pkg::FarZW-1:0]   far_z_o
);
  import lmlor_pkg::*;

  localparam logic [CoordW-1:0] PosScale   = 16'd59;
  localparam logic [PosW:0]     MirrorBase = 11'd1024;
  localparam logic [FarZW-1:0]  FarZOffset = 17'd10;

  logic [TimeW-1:0]  time_q, time_d;
  logic              out_valid_q, out_valid_d;
  logic [TimeW-1:0]  lor_time_q;
  logic [CoordW-1:0] x_near_q, y_near_q, x_far_q, y_far_q;
  logic [FarZW-1:0]  far_z_q;
  logic [PosW:0]     y_mirror;
  logic              load;

  // an emitting entry waits until the output register is free
  assign pop_o    = !qstat_i.empty && (!head_i.emit || !out_valid_q || out_ready_i);
  assign load     = pop_o && head_i.emit;
  assign time_d   = pop_o ? time_q + TimeW'(head_i.inc) : time_q;
  assign y_mirror = MirrorBase - {1'b0, head_i.yf};

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      time_q      <= time_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      lor_time_q <= time_d;
      x_near_q   <= CoordW'(head_i.xn) * PosScale;
      y_near_q   <= CoordW'(head_i.yn) * PosScale;
      x_far_q    <= CoordW'(head_i.xf) * PosScale;
      y_far_q    <= CoordW'(y_mirror) * PosScale;
      far_z_q    <= FarZW'(head_spacing_i) + FarZOffset;
    end
  end

  assign out_valid_o = out_valid_q;
  assign lor_time_o  = lor_time_q;
  assign x_near_o    = x_near_q;
  assign y_near_o    = y_near_q;
  assign x_far_o     = x_far_q;
  assign y_far_o     = y_far_q;
  assign far_z_o     = far_z_q;

endmodule

### tb/sv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lmlor_pkg::*;

  localparam logic [WordW-1:0] MarkerWord = 32'hFACE_FACE;
  localparam logic [7:0]       TagJump    = 8'd130;
  localparam logic [2:0]       AddrMsPerTick = 3'h0;
  localparam logic [2:0]       AddrScreenSep = 3'h4;

  localparam int XNear = 0;
  localparam int YNear = 1;
  localparam int XFar  = 2;
  localparam int YFar  = 3;

  localparam logic [5:0] SeenXn     = 6'h01;
  localparam logic [5:0] SeenYn     = 6'h02;
  localparam logic [5:0] SeenXf     = 6'h04;
  localparam logic [5:0] SeenYf     = 6'h08;
  localparam logic [5:0] SeenFirst  = 6'h10;
  localparam logic [5:0] SeenSecond = 6'h20;
  localparam logic [5:0] SeenCoords = 6'h0F;
  localparam logic [5:0] SeenAll    = 6'h3F;

  localparam int SettleCycles = 20;
  localparam int HoldAt       = 650;
  localparam int HoldCycles   = 300;

  typedef struct packed {
    logic [TimeW-1:0]  lor_time;
    logic [CoordW-1:0] x_near;
    logic [CoordW-1:0] y_near;
    logic [CoordW-1:0] x_far;
    logic [CoordW-1:0] y_far;
    logic [FarZW-1:0]  far_z;
  } lor_t;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  logic [WordW-1:0]  word_i      = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [TimeW-1:0]  lor_time_o;
  logic [CoordW-1:0] x_near_o;
  logic [CoordW-1:0] y_near_o;
  logic [CoordW-1:0] x_far_o;
  logic [CoordW-1:0] y_far_o;
  logic [FarZW-1:0]  far_z_o;
  logic              psel        = 1'b0;
  logic              penable     = 1'b0;
  logic              pwrite      = 1'b0;
  logic [2:0]        paddr       = '0;
  logic [31:0]       pwdata      = '0;
  logic [31:0]       prdata;
  logic              pready;

  gamma_camera_listmode_lor_decoder_unit uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .word_i     (word_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .lor_time_o (lor_time_o),
    .x_near_o   (x_near_o),
    .y_near_o   (y_near_o),
    .x_far_o    (x_far_o),
    .y_far_o    (y_far_o),
    .far_z_o    (far_z_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // decoder copy: configuration and state
  logic [TickW-1:0] tick_cfg  = 32'h0100_0000;
  logic [SepW-1:0]  sep_cfg   = '0;
  logic             skip_word = 1'b0;
  logic [7:0]       last_tag  = '0;
  logic [TimeW-1:0] time_ms   = '0;
  logic [PosW-1:0]  coord [4] = '{default: '0};
  logic [5:0]       seen      = '0;

  logic [WordW-1:0] word_q [$];
  lor_t             lor_q [$];
  lor_t             want;
  logic [7:0]       gen_tag   = '0;
  bit               calm      = 1'b0;
  int               words_in  = 0;
  int               hold_left = 0;
  bit               hold_done = 1'b0;
  int               errors    = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [PosW-1:0] position_of(input logic [WordW-1:0] w);
    logic [13:0] s;
    s = {w[8], w[10], w[12], w[14], w[16], w[21], w[19], w[18],
         w[11], w[13], w[15], w[17], w[22], w[20]};
    return ~s[13:4];
  endfunction

  task automatic predict_word(input logic [WordW-1:0] w);
    logic [7:0]      tag_step;
    logic [PosW-1:0] p;
    logic            far_head;
    lor_t            line;
    if (skip_word) begin
      skip_word = 1'b0;
    end else if (w == MarkerWord) begin
      skip_word = 1'b1;
    end else begin
      tag_step = w[31:24] - last_tag;
      last_tag = w[31:24];
      if (tag_step < TagJump) time_ms += 64'(tag_step) * 64'(tick_cfg);
      p = position_of(w);
      far_head = !w[23];
      if (!w[7]) begin
        // a first-of-pair x starts a fresh set of coordinates
        if (w[22]) seen |= SeenSecond;
        else seen = (seen | SeenFirst) & ~SeenCoords;
        if (far_head) begin
          coord[XFar] = p;
          seen |= SeenXf;
        end else begin
          coord[XNear] = p;
          seen |= SeenXn;
        end
      end
      if (!w[9]) begin
        if (far_head) begin
          coord[YFar] = p;
          seen |= SeenYf;
        end else begin
          coord[YNear] = p;
          seen |= SeenYn;
        end
      end
      if (seen == SeenAll) begin
        line.lor_time = time_ms;
        line.x_near   = 16'(coord[XNear]) * 16'd59;
        line.y_near   = 16'(coord[YNear]) * 16'd59;
        line.x_far    = 16'(coord[XFar]) * 16'd59;
        line.y_far    = (16'd1024 - 16'(coord[YFar])) * 16'd59;
        line.far_z    = 17'(sep_cfg) + 17'd10;
        lor_q.push_back(line);
        seen = '0;
      end
    end
  endtask

  // builds a data word carrying the given position and trigger bits
  function automatic logic [WordW-1:0] event_word(input logic [7:0] tag,
                                                  input logic [PosW-1:0] p,
                                                  input bit tx, input bit ty,
                                                  input bit far_head, input bit second);
    logic [13:0]      s;
    logic [WordW-1:0] w;
    w = $urandom;
    s = {~p, 4'($urandom)};
    s[1] = second;
    {w[8], w[10], w[12], w[14], w[16], w[21], w[19], w[18],
     w[11], w[13], w[15], w[17], w[22], w[20]} = s;
    w[7]     = !tx;
    w[9]     = !ty;
    w[23]    = !far_head;
    w[31:24] = tag;
    return w;
  endfunction

  function automatic logic [PosW-1:0] pick_pos();
    int r;
    r = $urandom_range(9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return PosW'($urandom);
  endfunction

  function automatic logic [7:0] advance_tag();
    int r;
    r = $urandom_range(99);
    if (r < 80) gen_tag += 8'($urandom_range(3));
    else if (r < 95) gen_tag += 8'($urandom_range(129, 4));
    else gen_tag += 8'($urandom_range(255, 130));
    return gen_tag;
  endfunction

  // retagging cannot turn an event word that carries a trigger into a marker
  task automatic push_event(input logic [WordW-1:0] w);
    w[31:24] = advance_tag();
    word_q.push_back(w);
  endtask

  task automatic push_line_words(input bit complete);
    logic [WordW-1:0] rest [$];
    bit               head;
    bit               y_first;
    bit               y_other;
    head    = $urandom_range(1);
    y_first = $urandom_range(1);
    y_other = $urandom_range(1);
    push_event(event_word(8'h00, pick_pos(), 1'b1, y_first, head, 1'b0));
    rest.push_back(event_word(8'h00, pick_pos(), 1'b1, y_other, !head, 1'b1));
    if (!y_first)
      rest.insert($urandom_range(rest.size()),
                  event_word(8'h00, pick_pos(), 1'b0, 1'b1, head, $urandom_range(1)));
    if (!y_other)
      rest.insert($urandom_range(rest.size()),
                  event_word(8'h00, pick_pos(), 1'b0, 1'b1, !head, $urandom_range(1)));
    if (!complete) rest.delete($urandom_range(rest.size() - 1));
    while (rest.size() != 0) begin
      // buffer start in mid pair: marker plus swallowed time stamp
      if ($urandom_range(9) == 0) begin
        word_q.push_back(MarkerWord);
        word_q.push_back($urandom);
      end
      push_event(rest.pop_front());
    end
  endtask

  task automatic add_random_group();
    int r;
    r = $urandom_range(99);
    if (r < 63) begin
      push_line_words(1'b1);
    end else if (r < 70) begin
      push_line_words(1'b0);
    end else if (r < 80) begin
      word_q.push_back($urandom);
    end else if (r < 88) begin
      word_q.push_back(MarkerWord);
      word_q.push_back(($urandom_range(3) == 0) ? MarkerWord : $urandom);
    end else begin
      push_event(event_word(8'h00, pick_pos(), $urandom_range(1), $urandom_range(1),
                            $urandom_range(1), $urandom_range(1)));
    end
  endtask

  task automatic cfg_write(input logic [2:0] addr, input logic [31:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (addr)
      AddrMsPerTick: tick_cfg = data;
      AddrScreenSep: sep_cfg  = data[SepW-1:0];
      default: ;
    endcase
  endtask

  task automatic settle();
    while (word_q.size() != 0 || in_valid_i || lor_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic run_phase(input logic [31:0] tick, input logic [15:0] sep,
                           input bit calm_v, input int n);
    settle();
    cfg_write(AddrMsPerTick, tick);
    cfg_write(AddrScreenSep, {16'd0, sep});
    calm = calm_v;
    while (word_q.size() < n) add_random_group();
  endtask

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, exp_v, got_v);
      errors++;
    end
  endtask

  // input side
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        predict_word(word_i);
        words_in <= words_in + 1;
      end
      if (!in_valid_i || in_ready_o) begin
        if (word_q.size() != 0 && (calm || $urandom_range(99) >= 35)) begin
          in_valid_i <= 1'b1;
          word_i     <= word_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // one long receiver hold-off while words keep coming
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && words_in >= HoldAt) begin
      hold_left <= HoldCycles;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // output side
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (lor_q.size() == 0) begin
          $display("%0t: line transfer with none expected, time %0h", $time, lor_time_o);
          errors++;
        end else begin
          want = lor_q.pop_front();
          check_field("lor_time", want.lor_time, lor_time_o);
          check_field("x_near", 64'(want.x_near), 64'(x_near_o));
          check_field("y_near", 64'(want.y_near), 64'(y_near_o));
          check_field("x_far", 64'(want.x_far), 64'(x_far_o));
          check_field("y_far", 64'(want.y_far), 64'(y_far_o));
          check_field("far_z", 64'(want.far_z), 64'(far_z_o));
        end
      end
      out_ready_i <= (hold_left == 0) && (calm || $urandom_range(99) >= 35);
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed words under reset configuration
    word_q.push_back(32'h0000_0000);       // x and y far, first of pair
    word_q.push_back(32'hFFFF_FFFF);       // no trigger, tag jump of 255
    word_q.push_back(MarkerWord);
    word_q.push_back(MarkerWord);          // marker in the time stamp slot is dropped
    word_q.push_back(event_word(8'h7F, 10'd0, 1'b1, 1'b1, 1'b0, 1'b0));
    word_q.push_back(MarkerWord);
    word_q.push_back(event_word(8'h00, 10'd1023, 1'b1, 1'b1, 1'b1, 1'b1));
    word_q.push_back(event_word(8'h01, 10'd1023, 1'b1, 1'b1, 1'b1, 1'b1)); // step 130
    word_q.push_back(event_word(8'h82, 10'd1023, 1'b1, 1'b1, 1'b0, 1'b0)); // step 129
    word_q.push_back(event_word(8'h83, 10'd0, 1'b0, 1'b1, 1'b1, 1'b0));
    word_q.push_back(event_word(8'h02, 10'd512, 1'b1, 1'b0, 1'b1, 1'b1));  // wraps
    word_q.push_back(event_word(8'h02, 10'd300, 1'b1, 1'b0, 1'b0, 1'b1));  // second first
    word_q.push_back(event_word(8'hFF, 10'd700, 1'b0, 1'b1, 1'b0, 1'b0));
    word_q.push_back(event_word(8'h01, 10'd5, 1'b1, 1'b0, 1'b1, 1'b0));    // clears coords
    word_q.push_back(32'h7FFF_FF7F);
    word_q.push_back(32'h8000_0280);

    run_phase(32'hFFFF_FFFF, 16'hFFFF, 1'b0, 250);
    run_phase(32'h0000_0000, 16'h0000, 1'b0, 250);
    run_phase($urandom, 16'($urandom), 1'b1, 300);
    run_phase(32'h0100_0000, 16'($urandom), 1'b0, 200);
    run_phase(32'($urandom_range(255, 1)) << 16, 16'hFFFF, 1'b0, 200);
    settle();

    if (errors == 0) begin
      $display("gamma_camera_listmode_lor_decoder_unit: match");
    end else begin
      $display("gamma_camera_listmode_lor_decoder_unit: mismatch");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("gamma_camera_listmode_lor_decoder_unit: mismatch");
    $finish;
  end

endmodule
